>>> rtl/core/ple_pkg.sv
// Package for the positional list engine: widths, operation and status codes,
// and the structs passed between the sequencer, the element store and the top level.
// No dependencies.
package ple_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int KIND_W   = 4;
  localparam int ST_W     = 2;

  typedef enum logic [KIND_W-1:0] {
    K_INS_FRONT = 4'd0,
    K_INS_BACK  = 4'd1,
    K_INS_AT    = 4'd2,
    K_DEL_FRONT = 4'd3,
    K_DEL_BACK  = 4'd4,
    K_DEL_AT    = 4'd5,
    K_READ      = 4'd6,
    K_FIND      = 4'd7,
    K_CLEAR     = 4'd8
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic signed [POS_W-1:0] found_position;
    logic [CNT_W-1:0]        length;
    status_t                 status;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> rtl/core/ple_mem.sv
// Element store of the positional list engine: one write port, one read port,
// registered read data. Depends on ple_pkg.
module ple_mem (
  input  logic                           clk,
  input  ple_pkg::mem_req_t              mreq,
  output logic [ple_pkg::VAL_W-1:0]      rdata
);
  import ple_pkg::*;

  logic [VAL_W-1:0] mem_r [CAPACITY];
  logic [VAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem_r[mreq.waddr] <= mreq.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.re) begin
      rdata_r <= mem_r[mreq.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ple_ctrl.sv
// Sequencer of the positional list engine: decodes a request and steps a shared
// cursor adder and equality compare over the element store. Depends on ple_pkg.
module ple_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  ple_pkg::request_t          req,
  input  logic                       res_free,
  output logic                       res_valid,
  output ple_pkg::result_t           res,
  output ple_pkg::mem_req_t          mreq,
  input  logic [ple_pkg::VAL_W-1:0]  mem_rdata
);
  import ple_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SHIFT = 6'b000010,
    S_MOVE  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_MATCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [ADDR_W-1:0] lim_r, lim_nxt;
  logic              up_r, up_nxt;
  logic              rd_mode_r, rd_mode_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [VAL_W-1:0]  rd_r, rd_nxt;
  logic [POS_W-1:0]  fp_r, fp_nxt;
  status_t           st_r, st_nxt;

  logic [ADDR_W-1:0] step;
  logic              at_lim;
  logic [CNT_W-1:0]  cnt_m1;
  logic              full;
  logic              pos_gt;
  logic              pos_ge;

  // Shared unit: the cursor moves one place up or down and is checked against its end.
  assign step   = up_r ? idx_r + 1'b1 : idx_r - 1'b1;
  assign at_lim = (idx_r == lim_r);
  assign cnt_m1 = count_r - 1'b1;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign pos_gt = (req.position > count_r);
  assign pos_ge = (req.position >= count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    lim_nxt     = lim_r;
    up_nxt      = up_r;
    rd_mode_nxt = rd_mode_r;
    val_nxt     = val_r;
    rd_nxt      = rd_r;
    fp_nxt      = fp_r;
    st_nxt      = st_r;
    mreq        = '0;
    res_valid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          val_nxt     = req.value;
          rd_nxt      = '1;
          fp_nxt      = '1;
          st_nxt      = ST_OK;
          rd_mode_nxt = 1'b0;
          state_nxt   = S_DONE;
          unique case (kind_t'(req.kind))
            K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
              if (kind_t'(req.kind) == K_INS_AT && pos_gt) begin
                st_nxt = ST_RANGE;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                idx_nxt = count_r[ADDR_W-1:0];
                if (kind_t'(req.kind) == K_INS_FRONT) begin
                  lim_nxt = '0;
                end else if (kind_t'(req.kind) == K_INS_BACK) begin
                  lim_nxt = count_r[ADDR_W-1:0];
                end else begin
                  lim_nxt = req.position[ADDR_W-1:0];
                end
                up_nxt    = 1'b0;
                state_nxt = S_SHIFT;
              end
            end
            K_DEL_FRONT, K_DEL_BACK: begin
              if (count_r == '0) begin
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt   = (kind_t'(req.kind) == K_DEL_FRONT) ? '0 : cnt_m1[ADDR_W-1:0];
                lim_nxt   = cnt_m1[ADDR_W-1:0];
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            K_DEL_AT: begin
              if (pos_ge) begin
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt   = req.position[ADDR_W-1:0];
                lim_nxt   = cnt_m1[ADDR_W-1:0];
                up_nxt    = 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            K_READ: begin
              if (pos_ge) begin
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt     = req.position[ADDR_W-1:0];
                rd_mode_nxt = 1'b1;
                state_nxt   = S_SCAN;
              end
            end
            K_FIND: begin
              st_nxt = ST_ABSENT;
              if (count_r != '0) begin
                idx_nxt   = '0;
                lim_nxt   = cnt_m1[ADDR_W-1:0];
                up_nxt    = 1'b1;
                state_nxt = S_SCAN;
              end
            end
            K_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (!at_lim) begin
          mreq.re    = 1'b1;
          mreq.raddr = step;
          state_nxt  = S_MOVE;
        end else begin
          if (!up_r) begin
            mreq.we    = 1'b1;
            mreq.waddr = idx_r;
            mreq.wdata = val_r;
            count_nxt  = count_r + 1'b1;
          end else begin
            count_nxt  = cnt_m1;
          end
          state_nxt = S_DONE;
        end
      end
      S_MOVE: begin
        mreq.we    = 1'b1;
        mreq.waddr = idx_r;
        mreq.wdata = mem_rdata;
        idx_nxt    = step;
        state_nxt  = S_SHIFT;
      end
      S_SCAN: begin
        mreq.re    = 1'b1;
        mreq.raddr = idx_r;
        state_nxt  = S_MATCH;
      end
      S_MATCH: begin
        if (rd_mode_r) begin
          rd_nxt    = mem_rdata;
          state_nxt = S_DONE;
        end else if (mem_rdata == val_r) begin
          fp_nxt    = POS_W'(idx_r);
          st_nxt    = ST_OK;
          state_nxt = S_DONE;
        end else if (at_lim) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = step;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        res_valid = res_free;
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    lim_r     <= lim_nxt;
    up_r      <= up_nxt;
    rd_mode_r <= rd_mode_nxt;
    val_r     <= val_nxt;
    rd_r      <= rd_nxt;
    fp_r      <= fp_nxt;
    st_r      <= st_nxt;
  end

  assign req_ready          = (state_r == S_IDLE);
  assign res.read_value     = rd_r;
  assign res.found_position = fp_r;
  assign res.length         = count_r;
  assign res.status         = st_r;

endmodule

>>> rtl/core/positional_list_engine_top.sv
// Positional list engine, top level. Inserts and deletes shift the entries between
// the position and the end by read-then-write moves through the store, whose read data
// is registered; reads and finds fetch entries through the same registered read port.
// One request at a time; the next is taken once the result is registered.
// Synchronous active-low reset empties the list; stored values are not cleared.
module positional_list_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value [31:0], position [38:32], zero [39]
  input  logic [3:0]  in_tuser,   // kind [3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value [31:0], found_position [38:32],
                                  // length [45:39], status [47:46]
);
  import ple_pkg::*;

  request_t  req;
  result_t   res;
  mem_req_t  mreq;
  logic [VAL_W-1:0] mem_rdata;
  logic      res_valid;
  logic      res_free;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;

  // Unpack the incoming transaction into the request fields.
  assign req.kind     = in_tuser;
  assign req.value    = in_tdata[31:0];
  assign req.position = in_tdata[38:32];

  // The sequencer decodes each request, walks the store one entry per move and
  // holds the list length.
  ple_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (req),
    .res_free  (res_free),
    .res_valid (res_valid),
    .res       (res),
    .mreq      (mreq),
    .mem_rdata (mem_rdata)
  );

  ple_mem u_mem (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (mem_rdata)
  );

  // Output register: it can take a new result when empty or when the current one
  // leaves in the same cycle, so the sequencer returns to idle without waiting.
  assign res_free = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {res.status, res.length, res.found_position, res.read_value};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A request always takes the engine out of the idle state in the cycle after it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("engine ready right after accepting a request");

  // A result is only produced when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_tready))
    else $error("pending result overwritten");

  // The reported length never exceeds the capacity.
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[45:39] <= CNT_W'(CAPACITY)))
    else $error("length beyond capacity");

  // A full refusal is only reported when the list is at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[47:46] == ST_FULL) |->
      (out_data_r[45:39] == CNT_W'(CAPACITY)))
    else $error("full status with room left");

endmodule

>>> dv/positional_list_engine_top_tb.sv
// Self-checking testbench for the positional list engine top level.
// Depends on ple_pkg (kind and status codes, request and result structs) and on
// positional_list_engine_top; needs nothing else.
`timescale 1ns / 100ps

module positional_list_engine_top_tb;
  import ple_pkg::*;

  // Kinds outside the defined set; the block must treat them as no-ops.
  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 4'd15;

  localparam int NUM_RANDOM = 800;
  // Quiet tail: the last requests and results run with no idling on either side.
  localparam int TAIL_LEN = 100;
  // Slowest single transaction is an absent find on a full list, plus the longest
  // stall on each side, so reaching the hang limit in idle cycles means a hang.
  localparam int HANG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 200;

  // Stream modes used to shape the random part.
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;   // value [31:0], position [38:32], zero [39]
  logic [3:0] in_tuser = '0;    // kind [3:0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;       // read_value [31:0], found_position [38:32],
                                // length [45:39], status [47:46]

  positional_list_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Requests waiting for the driver, and results the block still owes us.
  request_t request_queue[$];
  result_t  expected_results[$];

  // Our own image of the list, updated once per accepted request.
  logic signed [VAL_W-1:0] list_vals[CAPACITY];
  int list_len = 0;

  // Length the list will have after everything queued so far; used only to aim
  // positions at the valid range while generating.
  int shadow_len = 0;

  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int tail_start = 0;
  int peak_len = 0;
  int n_full = 0;
  int n_range = 0;
  int n_find_hits = 0;
  int n_absent = 0;

  // Computes the result of one request and applies it to the list image.
  function automatic result_t apply_request(logic [KIND_W-1:0] k, logic signed [VAL_W-1:0] v,
                                            logic [POS_W-1:0] p);
    result_t r;
    int at;
    bit do_ins;
    bit do_del;
    at = 0;
    do_ins = 1'b0;
    do_del = 1'b0;
    r.read_value = -1;
    r.found_position = '1;
    r.status = ST_OK;
    case (k)
      K_INS_FRONT, K_INS_BACK: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          at = (k == K_INS_FRONT) ? 0 : list_len;
        end
      end
      K_INS_AT: begin
        // The position is checked before fullness.
        if (int'(p) > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          do_ins = 1'b1;
          at = int'(p);
        end
      end
      K_DEL_FRONT, K_DEL_BACK: begin
        if (list_len == 0) begin
          r.status = ST_RANGE;
        end else begin
          do_del = 1'b1;
          at = (k == K_DEL_FRONT) ? 0 : list_len - 1;
        end
      end
      K_DEL_AT: begin
        if (int'(p) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          do_del = 1'b1;
          at = int'(p);
        end
      end
      K_READ: begin
        if (int'(p) >= list_len) r.status = ST_RANGE;
        else r.read_value = list_vals[p[ADDR_W-1:0]];
      end
      K_FIND: begin
        r.status = ST_ABSENT;
        for (int i = 0; i < list_len; i++) begin
          if (list_vals[i] == v) begin
            r.found_position = i[POS_W-1:0];
            r.status = ST_OK;
            break;
          end
        end
      end
      K_CLEAR: list_len = 0;
      default: ;
    endcase
    if (do_ins) begin
      for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i-1];
      list_vals[at] = v;
      list_len++;
    end
    if (do_del) begin
      for (int i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
      list_len--;
    end
    r.length = list_len[CNT_W-1:0];
    return r;
  endfunction

  // Queues one request and tracks the list length it will leave behind.
  task automatic queue_request(input logic [KIND_W-1:0] k, input logic signed [VAL_W-1:0] v,
                               input int p);
    request_t req;
    req.kind = k;
    req.value = v;
    req.position = p[POS_W-1:0];
    request_queue.push_back(req);
    case (k)
      K_INS_FRONT, K_INS_BACK: if (shadow_len < CAPACITY) shadow_len++;
      K_INS_AT: if (p <= shadow_len && shadow_len < CAPACITY) shadow_len++;
      K_DEL_FRONT, K_DEL_BACK: if (shadow_len > 0) shadow_len--;
      K_DEL_AT: if (p < shadow_len) shadow_len--;
      K_CLEAR: shadow_len = 0;
      default: ;
    endcase
  endtask

  // Values lean on a small pool and the extremes so that finds hit duplicates.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 7)) - 3;
      4: return 32'h8000_0000;
      5: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint seen);
    $display("MISMATCH on result %0d, %s: expected %0d, got %0d", n_checked, what, want, seen);
    n_errors++;
  endtask

  // Driver: presents queued requests, holds them while in_tready is low, and
  // idles in random bursts until the quiet tail. Each accepted transaction is
  // run through the predictor at once, so expectations stay in order.
  request_t cur_req;
  int in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(cur_req.kind, cur_req.value,
                                                 cur_req.position));
        n_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // The request stays on the bus until the block takes it.
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (n_sent < tail_start && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 11);
        in_tvalid <= 1'b0;
      end else begin
        cur_req = request_queue.pop_front();
        in_tdata <= {1'b0, cur_req.position, cur_req.value};
        in_tuser <= cur_req.kind;
        in_tvalid <= 1'b1;
      end
    end
  end

  // Monitor: checks every result transaction against the oldest expectation,
  // field by field, and stalls out_tready in random bursts until the quiet tail.
  int out_stall = 0;

  always @(posedge clk) begin
    logic signed [VAL_W-1:0] got_rd;
    logic signed [POS_W-1:0] got_fp;
    logic [CNT_W-1:0] got_len;
    logic [ST_W-1:0] got_st;
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rd = out_tdata[31:0];
        got_fp = out_tdata[38:32];
        got_len = out_tdata[45:39];
        got_st = out_tdata[47:46];
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request pending, read_value", 0, got_rd);
        end else begin
          want = expected_results.pop_front();
          if (got_rd !== want.read_value)
            report_mismatch("read_value", want.read_value, got_rd);
          if (got_fp !== want.found_position)
            report_mismatch("found_position", want.found_position, got_fp);
          if (got_len !== want.length)
            report_mismatch("length", want.length, got_len);
          if (got_st !== want.status)
            report_mismatch("status", want.status, got_st);
          if (int'(want.length) > peak_len) peak_len = int'(want.length);
          case (want.status)
            ST_FULL: n_full++;
            ST_RANGE: n_range++;
            ST_ABSENT: n_absent++;
            default: if (want.found_position != '1) n_find_hits++;
          endcase
        end
        n_checked++;
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else if (n_checked < tail_start && $urandom_range(0, 7) == 0) begin
        out_stall = $urandom_range(0, 11);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: counts cycles with work outstanding but no transaction on either
  // side, and gives up once that count reaches the hang limit.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else if (request_queue.size() != 0 || in_tvalid || expected_results.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
          $display("Timeout: no transaction for %0d cycles", idle_cycles);
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus: a directed opening, a full drain, then random requests shaped in
  // phases that lean towards filling the list, emptying it, or mix operations.
  initial begin
    int mode;
    int phase_left;
    int r;
    int ins_w;
    int del_w;
    int p;
    logic [KIND_W-1:0] k;

    // Everything on an empty list is rejected, including an insert past the end.
    queue_request(K_READ, 0, 0);
    queue_request(K_DEL_FRONT, 0, 0);
    queue_request(K_DEL_BACK, 0, 0);
    queue_request(K_DEL_AT, 0, 0);
    queue_request(K_FIND, 0, 0);
    queue_request(K_INS_AT, 5, 1);
    // Build a short list with the value extremes, inserting at the front, the
    // back, the middle and exactly at the end.
    queue_request(K_INS_FRONT, 32'h8000_0000, 0);
    queue_request(K_INS_BACK, 32'h7fff_ffff, 0);
    queue_request(K_INS_AT, 0, 1);
    queue_request(K_INS_AT, -1, 3);
    queue_request(K_INS_AT, 7, 0);
    queue_request(K_READ, 0, 0);
    queue_request(K_READ, 0, 4);
    queue_request(K_READ, 0, 127);
    queue_request(K_FIND, 32'h7fff_ffff, 0);
    queue_request(K_FIND, 12345, 0);
    queue_request(K_DEL_AT, 0, 1);
    queue_request(K_DEL_AT, 0, 127);
    queue_request(K_DEL_FRONT, 0, 0);
    queue_request(K_DEL_BACK, 0, 0);
    // Undefined kinds must leave the list alone.
    queue_request(KIND_UNUSED_LO, 0, 0);
    queue_request(KIND_UNUSED_HI, -1, 127);
    queue_request(K_CLEAR, 0, 0);
    queue_request(K_READ, 0, 0);
    tail_start = request_queue.size() + NUM_RANDOM - TAIL_LEN;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Hold off the random part until every directed result is back.
    while (request_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);

    phase_left = 0;
    mode = MODE_MIXED;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (phase_left == 0) begin
        r = $urandom_range(0, 9);
        mode = (r < 4) ? MODE_FILL : (r < 7) ? MODE_DRAIN : MODE_MIXED;
        phase_left = $urandom_range(60, 180);
      end
      phase_left--;
      ins_w = (mode == MODE_FILL) ? 60 : (mode == MODE_DRAIN) ? 15 : 38;
      del_w = 75 - ins_w;
      r = $urandom_range(0, 99);
      if (r < ins_w) k = KIND_W'($urandom_range(K_INS_FRONT, K_INS_AT));
      else if (r < 75) k = KIND_W'($urandom_range(K_DEL_FRONT, K_DEL_AT));
      else if (r < 87) k = K_READ;
      else if (r < 97) k = K_FIND;
      else if (r < 99) k = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
      else k = K_CLEAR;
      // Most positions land inside the list; the rest span the whole field.
      if ($urandom_range(0, 99) < 12) p = $urandom_range(0, 127);
      else if (k == K_INS_AT) p = $urandom_range(0, shadow_len);
      else if (shadow_len > 0) p = $urandom_range(0, shadow_len - 1);
      else p = 0;
      queue_request(k, pick_value(), p);
    end

    while (request_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results; the list peaked at %0d entries, %0d inserts refused as full.",
             n_checked, peak_len, n_full);
    $display("Rejected positions or empty list: %0d; finds hit %0d times, missed %0d times.",
             n_range, n_find_hits, n_absent);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
